// File: hdl/risc_instruction_execute_unit_macros.svh
// Assertion macros for the instruction execute unit.
`ifndef RISC_INSTRUCTION_EXECUTE_UNIT_MACROS_SVH
`define RISC_INSTRUCTION_EXECUTE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RIEU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rieu: assertion failed");
`define RIEU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rieu: assertion failed");
`else
`define RIEU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define RIEU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/rieu_pkg.sv
// Types and constants shared by the instruction execute unit.
package rieu_pkg;

	localparam logic [31:0] PC_BASE        = 32'd4000;
	localparam logic [31:0] WORD_BYTES     = 32'd4;
	localparam int          CW_W           = 13;
	localparam logic [12:0] CODE_WORDS_RST = 13'd4096;

	typedef enum logic [3:0] {
		OP_MOVC  = 4'd0,
		OP_ADD   = 4'd1,
		OP_SUB   = 4'd2,
		OP_MUL   = 4'd3,
		OP_AND   = 4'd4,
		OP_OR    = 4'd5,
		OP_EXOR  = 4'd6,
		OP_LOAD  = 4'd7,
		OP_STORE = 4'd8,
		OP_BZ    = 4'd9,
		OP_BNZ   = 4'd10,
		OP_JUMP  = 4'd11,
		OP_HALT  = 4'd12
	} op_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic        wr;
		logic [4:0]  idx;
		logic [31:0] value;
		logic        load;
		logic        zero;
		logic        halt;
		logic        fault;
		logic        mem_re;
		logic        mem_we;
		logic [29:0] mem_widx;
		logic [31:0] mem_wdata;
	} exe_res_t;

	function automatic logic [31:0] last_pc(input logic [CW_W-1:0] cw);
		logic [31:0] cw_bytes;
		cw_bytes = {17'd0, cw, 2'b00};
		return PC_BASE + cw_bytes - WORD_BYTES;
	endfunction

endpackage

// File: hdl/rieu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rieu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/rieu_exec.sv
// Execute logic: decode, ALU, address and branch evaluation for one instruction.
module rieu_exec #(
	parameter int REG_COUNT  = 32,
	parameter int DATA_WORDS = 4096
) (
	input  logic [3:0]         op_code,
	input  logic [4:0]         rd,
	input  logic [31:0]        opa,
	input  logic [31:0]        opb,
	input  logic [31:0]        imm,
	input  logic [31:0]        pc,
	input  logic               zf,
	input  logic               halted,
	input  logic [31:0]        last_pc,
	output rieu_pkg::exe_res_t res
);

	rieu_pkg::op_t op;
	logic [31:0]   sum_a;
	logic [31:0]   sum_b;
	logic [31:0]   alu_res;
	logic          alu;
	logic          wr;
	logic          ld;
	logic          rd_ok;

	assign op    = rieu_pkg::op_t'(op_code);
	assign sum_a = opa + imm;
	assign sum_b = opb + imm;
	assign rd_ok = 32'(rd) < REG_COUNT;

	always_comb begin
		res         = '0;
		res.next_pc = pc + rieu_pkg::WORD_BYTES;
		res.zero    = zf;
		alu_res     = '0;
		alu         = 1'b0;
		wr          = 1'b0;
		ld          = 1'b0;
		unique case (op)
			rieu_pkg::OP_MOVC: begin
				alu_res = imm;
				alu     = 1'b1;
			end
			rieu_pkg::OP_ADD: begin
				alu_res = opa + opb;
				alu     = 1'b1;
			end
			rieu_pkg::OP_SUB: begin
				alu_res = opa - opb;
				alu     = 1'b1;
			end
			rieu_pkg::OP_MUL: begin
				alu_res = opa * opb;
				alu     = 1'b1;
			end
			rieu_pkg::OP_AND: begin
				alu_res = opa & opb;
				alu     = 1'b1;
			end
			rieu_pkg::OP_OR: begin
				alu_res = opa | opb;
				alu     = 1'b1;
			end
			rieu_pkg::OP_EXOR: begin
				alu_res = opa ^ opb;
				alu     = 1'b1;
			end
			rieu_pkg::OP_LOAD: begin
				res.mem_widx = sum_a[31:2];
				if (sum_a[31:2] < 30'(DATA_WORDS)) begin
					res.mem_re = 1'b1;
					wr         = 1'b1;
					ld         = 1'b1;
				end else begin
					res.fault = 1'b1;
				end
			end
			rieu_pkg::OP_STORE: begin
				res.mem_widx  = sum_b[31:2];
				res.mem_wdata = opa;
				if (sum_b[31:2] < 30'(DATA_WORDS)) begin
					res.mem_we = 1'b1;
				end else begin
					res.fault = 1'b1;
				end
			end
			rieu_pkg::OP_BZ: begin
				if (zf) begin
					res.next_pc = pc + imm;
				end
			end
			rieu_pkg::OP_BNZ: begin
				if (!zf) begin
					res.next_pc = pc + imm;
				end
			end
			rieu_pkg::OP_JUMP: begin
				res.next_pc = sum_a;
			end
			rieu_pkg::OP_HALT: begin
				res.halt = 1'b1;
			end
			default: begin
			end
		endcase
		if (alu) begin
			res.zero = (alu_res == 32'd0);
			wr       = 1'b1;
		end
		res.wr    = wr && rd_ok;
		res.idx   = res.wr ? rd : 5'd0;
		res.load  = res.wr && ld;
		res.value = (res.wr && !ld) ? alu_res : 32'd0;
		if (pc == last_pc) begin
			res.halt = 1'b1;
		end
		if (halted) begin
			res         = '0;
			res.next_pc = pc;
			res.zero    = zf;
			res.halt    = 1'b1;
		end
	end

endmodule

// File: hdl/risc_instruction_execute_unit.sv
// Top level of the instruction execute unit: pipeline, register file, data store.
//
// Usage:
// - Input channel (in_valid/in_ready) carries one fetched instruction per transfer.
// - Output channel (out_valid/out_ready) returns one result per instruction, in order.
// - cfg_wr_en/cfg_wr_data set the number of code words; write only while idle.
// - Each instruction passes the stage-1 registers, then the output register.
// - Throughput: one instruction per cycle unless stalled or clearing; execute stage
//   and output register overlap; operands bypass from output stage and last write.
// - Register file: two RAM copies read at input transfer, written as results leave.
// - Data store: one RAM, written by STORE and read by LOAD in the execute stage.
// - Reset: pc 4000, zero flag and halt clear, register file reads as zero.
//   After reset the data store is cleared, one word a cycle, all DATA_WORDS words
//   (4096 at the default); in_ready stays low during that pass.
// - Stall: while out_ready is low the result holds; one more instruction may be
//   taken into the execute stage, then in_ready drops.
`include "risc_instruction_execute_unit_macros.svh"

module risc_instruction_execute_unit #(
	parameter int REG_COUNT  = 32,
	parameter int DATA_WORDS = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [12:0]        cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         req_type,
	input  logic [4:0]         dest_reg,
	input  logic [4:0]         src_a_reg,
	input  logic [4:0]         src_b_reg,
	input  logic signed [31:0] literal,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        next_pc,
	output logic               reg_written,
	output logic [4:0]         written_index,
	output logic signed [31:0] written_value,
	output logic               zero_now,
	output logic               halted_now,
	output logic               address_fault
);

	localparam int RA_W = $clog2(REG_COUNT);
	localparam int DA_W = $clog2(DATA_WORDS);

	logic                 in_acc;
	logic                 s2_en;
	logic                 s1_adv;
	logic                 out_acc;

	logic                 vld_s1;
	logic [3:0]           op_s1;
	logic [4:0]           rd_s1;
	logic [4:0]           ra_s1;
	logic [4:0]           rb_s1;
	logic [31:0]          imm_s1;
	logic                 aok_s1;
	logic                 bok_s1;

	logic                 vld_s2;
	logic [31:0]          npc_s2;
	logic                 wr_s2;
	logic [4:0]           idx_s2;
	logic [31:0]          val_s2;
	logic                 ld_s2;
	logic                 zero_s2;
	logic                 halt_s2;
	logic                 fault_s2;

	logic [31:0]          pc_q;
	logic                 zf_q;
	logic                 halt_q;
	logic [31:0]          last_pc_q;
	logic                 clr_busy_q;
	logic [DA_W-1:0]      clr_cnt_q;
	logic [REG_COUNT-1:0] rf_vld_q;
	logic                 wb_vld_q;
	logic [4:0]           wb_idx_q;
	logic [31:0]          wb_val_q;

	logic [31:0]          rf_a_rdata;
	logic [31:0]          rf_b_rdata;
	logic                 rf_we;
	logic [31:0]          s2_val;
	logic [31:0]          opa;
	logic [31:0]          opb;
	logic                 a_in;
	logic                 b_in;

	logic                 dm_we;
	logic [DA_W-1:0]      dm_waddr;
	logic [31:0]          dm_wdata;
	logic                 dm_re;
	logic [31:0]          dm_rdata;

	rieu_pkg::exe_res_t   ex;

	assign s2_en    = !vld_s2 || out_ready;
	assign s1_adv   = vld_s1 && s2_en;
	assign in_ready = !clr_busy_q && (!vld_s1 || s2_en);
	assign in_acc   = in_valid && in_ready;
	assign out_acc  = vld_s2 && out_ready;

	assign a_in = 32'(src_a_reg) < REG_COUNT;
	assign b_in = 32'(src_b_reg) < REG_COUNT;

	assign s2_val = ld_s2 ? dm_rdata : val_s2;
	assign rf_we  = out_acc && wr_s2;

	always_comb begin
		if (vld_s2 && wr_s2 && (idx_s2 == ra_s1)) begin
			opa = s2_val;
		end else if (wb_vld_q && (wb_idx_q == ra_s1)) begin
			opa = wb_val_q;
		end else if (aok_s1) begin
			opa = rf_a_rdata;
		end else begin
			opa = 32'd0;
		end
		if (vld_s2 && wr_s2 && (idx_s2 == rb_s1)) begin
			opb = s2_val;
		end else if (wb_vld_q && (wb_idx_q == rb_s1)) begin
			opb = wb_val_q;
		end else if (bok_s1) begin
			opb = rf_b_rdata;
		end else begin
			opb = 32'd0;
		end
	end

	rieu_ram #(
		.WIDTH(32),
		.DEPTH(REG_COUNT)
	) u_rf_a (
		.clk  (clk),
		.we   (rf_we),
		.waddr(RA_W'(idx_s2)),
		.wdata(s2_val),
		.re   (in_acc),
		.raddr(RA_W'(src_a_reg)),
		.rdata(rf_a_rdata)
	);

	rieu_ram #(
		.WIDTH(32),
		.DEPTH(REG_COUNT)
	) u_rf_b (
		.clk  (clk),
		.we   (rf_we),
		.waddr(RA_W'(idx_s2)),
		.wdata(s2_val),
		.re   (in_acc),
		.raddr(RA_W'(src_b_reg)),
		.rdata(rf_b_rdata)
	);

	rieu_exec #(
		.REG_COUNT (REG_COUNT),
		.DATA_WORDS(DATA_WORDS)
	) u_exec (
		.op_code(op_s1),
		.rd     (rd_s1),
		.opa    (opa),
		.opb    (opb),
		.imm    (imm_s1),
		.pc     (pc_q),
		.zf     (zf_q),
		.halted (halt_q),
		.last_pc(last_pc_q),
		.res    (ex)
	);

	assign dm_we    = clr_busy_q || (s1_adv && ex.mem_we);
	assign dm_waddr = clr_busy_q ? clr_cnt_q : ex.mem_widx[DA_W-1:0];
	assign dm_wdata = clr_busy_q ? 32'd0 : ex.mem_wdata;
	assign dm_re    = s1_adv && ex.mem_re;

	rieu_ram #(
		.WIDTH(32),
		.DEPTH(DATA_WORDS)
	) u_dstore (
		.clk  (clk),
		.we   (dm_we),
		.waddr(dm_waddr),
		.wdata(dm_wdata),
		.re   (dm_re),
		.raddr(ex.mem_widx[DA_W-1:0]),
		.rdata(dm_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			pc_q       <= rieu_pkg::PC_BASE;
			zf_q       <= 1'b0;
			halt_q     <= 1'b0;
			last_pc_q  <= rieu_pkg::last_pc(rieu_pkg::CODE_WORDS_RST);
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
			rf_vld_q   <= '0;
			wb_vld_q   <= 1'b0;
		end else begin
			if (in_acc) begin
				vld_s1 <= 1'b1;
			end else if (s1_adv) begin
				vld_s1 <= 1'b0;
			end
			if (s2_en) begin
				vld_s2 <= vld_s1;
			end
			if (s1_adv) begin
				pc_q   <= ex.next_pc;
				zf_q   <= ex.zero;
				halt_q <= ex.halt;
			end
			if (cfg_wr_en) begin
				last_pc_q <= rieu_pkg::last_pc(cfg_wr_data);
			end
			if (clr_busy_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == DA_W'(DATA_WORDS - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (rf_we) begin
				rf_vld_q[RA_W'(idx_s2)] <= 1'b1;
				wb_vld_q                <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1  <= req_type;
			rd_s1  <= dest_reg;
			ra_s1  <= src_a_reg;
			rb_s1  <= src_b_reg;
			imm_s1 <= literal;
			aok_s1 <= a_in && rf_vld_q[RA_W'(src_a_reg)];
			bok_s1 <= b_in && rf_vld_q[RA_W'(src_b_reg)];
		end
		if (s1_adv) begin
			npc_s2   <= ex.next_pc;
			wr_s2    <= ex.wr;
			idx_s2   <= ex.idx;
			val_s2   <= ex.value;
			ld_s2    <= ex.load;
			zero_s2  <= ex.zero;
			halt_s2  <= ex.halt;
			fault_s2 <= ex.fault;
		end
		if (rf_we) begin
			wb_idx_q <= idx_s2;
			wb_val_q <= s2_val;
		end
	end

	assign out_valid     = vld_s2;
	assign next_pc       = npc_s2;
	assign reg_written   = wr_s2;
	assign written_index = idx_s2;
	assign written_value = s2_val;
	assign zero_now      = zero_s2;
	assign halted_now    = halt_s2;
	assign address_fault = fault_s2;

	`RIEU_ASSERT_IMPL(a_no_acc_clr, clk, arst_n, clr_busy_q, !in_ready)
	`RIEU_ASSERT_NEXT(a_halt_sticky, clk, arst_n, halt_q, halt_q)
	`RIEU_ASSERT_IMPL(a_rf_we_xfer, clk, arst_n, rf_we, out_valid && out_ready)
	`RIEU_ASSERT_IMPL(a_st_not_halted, clk, arst_n, dm_we && !clr_busy_q, s1_adv && !halt_q)
	`RIEU_ASSERT_IMPL(a_ld_writes, clk, arst_n, vld_s2 && ld_s2, wr_s2 && !fault_s2)

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the instruction execute unit: directed table, then random programs.
`timescale 1ns / 100ps

module tb_top;

	localparam logic [3:0] OP_FIRST_UNUSED = 4'd13;
	localparam logic [3:0] OP_LAST_UNUSED  = 4'd15;
	localparam int         MEM_WORDS       = 4096;
	localparam int         STALL_LIMIT     = 20000;
	localparam int         PHASE_ITEMS     = 300;

	typedef struct packed {
		logic [3:0]  op;
		logic [4:0]  rd;
		logic [4:0]  ra;
		logic [4:0]  rb;
		logic [31:0] lit;
	} instr_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic        wr;
		logic [4:0]  idx;
		logic [31:0] value;
		logic        zero;
		logic        halt;
		logic        fault;
	} retire_t;

	typedef struct {
		instr_t  ins;
		bit      typed;
		retire_t want;
	} plan_row_t;

	localparam retire_t NIL_RET = '0;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [12:0]        cfg_wr_data;
	logic               in_valid;
	logic               in_ready;
	logic [3:0]         req_type;
	logic [4:0]         dest_reg;
	logic [4:0]         src_a_reg;
	logic [4:0]         src_b_reg;
	logic signed [31:0] literal;
	logic               out_valid;
	logic               out_ready;
	logic [31:0]        next_pc;
	logic               reg_written;
	logic [4:0]         written_index;
	logic signed [31:0] written_value;
	logic               zero_now;
	logic               halted_now;
	logic               address_fault;

	logic [31:0] arch_regs [32]        = '{default: '0};
	logic [31:0] data_mem  [MEM_WORDS] = '{default: '0};
	logic [31:0] arch_pc = rieu_pkg::PC_BASE;
	logic        zflag   = 1'b0;
	logic        stopped = 1'b0;
	logic [12:0] cw_now  = rieu_pkg::CODE_WORDS_RST;

	retire_t pending_retire [$];
	int      mism_cnt    = 0;
	int      stall_count = 0;
	bit      calm        = 1'b0;

	plan_row_t plan [25] = '{
		'{'{rieu_pkg::OP_MOVC, 5'd1, 5'd0, 5'd0, 32'h7FFF_FFFF}, 1'b1,
			'{32'd4004, 1'b1, 5'd1, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0}},
		'{'{rieu_pkg::OP_MOVC, 5'd2, 5'd0, 5'd0, 32'h8000_0000}, 1'b1,
			'{32'd4008, 1'b1, 5'd2, 32'h8000_0000, 1'b0, 1'b0, 1'b0}},
		'{'{rieu_pkg::OP_MOVC, 5'd3, 5'd0, 5'd0, 32'h0000_0000}, 1'b1,
			'{32'd4012, 1'b1, 5'd3, 32'h0000_0000, 1'b1, 1'b0, 1'b0}},
		'{'{rieu_pkg::OP_MOVC, 5'd31, 5'd0, 5'd0, 32'hFFFF_FFFF}, 1'b1,
			'{32'd4016, 1'b1, 5'd31, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0}},
		'{'{rieu_pkg::OP_LOAD, 5'd11, 5'd3, 5'd0, 32'd16384}, 1'b1,
			'{32'd4020, 1'b0, 5'd0, 32'd0, 1'b0, 1'b0, 1'b1}},
		'{'{rieu_pkg::OP_STORE, 5'd0, 5'd1, 5'd2, 32'd0}, 1'b1,
			'{32'd4024, 1'b0, 5'd0, 32'd0, 1'b0, 1'b0, 1'b1}},
		'{'{rieu_pkg::OP_STORE, 5'd0, 5'd2, 5'd31, 32'hFFFF_FFFD}, 1'b1,
			'{32'd4028, 1'b0, 5'd0, 32'd0, 1'b0, 1'b0, 1'b1}},
		'{'{rieu_pkg::OP_ADD, 5'd4, 5'd1, 5'd2, 32'd0}, 1'b0, NIL_RET},
		'{'{rieu_pkg::OP_SUB, 5'd5, 5'd2, 5'd1, 32'd0}, 1'b0, NIL_RET},
		'{'{rieu_pkg::OP_MUL, 5'd6, 5'd31, 5'd2, 32'd0}, 1'b0, NIL_RET},
		'{'{rieu_pkg::OP_AND, 5'd7, 5'd31, 5'd1, 32'd0}, 1'b0, NIL_RET},
		'{'{rieu_pkg::OP_OR, 5'd8, 5'd2, 5'd1, 32'd0}, 1'b0, NIL_RET},
		'{'{rieu_pkg::OP_EXOR, 5'd9, 5'd31, 5'd31, 32'd0}, 1'b0, NIL_RET},
		'{'{rieu_pkg::OP_STORE, 5'd0, 5'd1, 5'd3, 32'd16380}, 1'b0, NIL_RET},
		'{'{rieu_pkg::OP_STORE, 5'd0, 5'd2, 5'd31, 32'd1}, 1'b0, NIL_RET},
		'{'{rieu_pkg::OP_LOAD, 5'd10, 5'd3, 5'd0, 32'd16380}, 1'b0, NIL_RET},
		'{'{rieu_pkg::OP_LOAD, 5'd12, 5'd31, 5'd0, 32'd1}, 1'b0, NIL_RET},
		'{'{rieu_pkg::OP_BZ, 5'd0, 5'd0, 5'd0, 32'd8}, 1'b0, NIL_RET},
		'{'{rieu_pkg::OP_BNZ, 5'd0, 5'd0, 5'd0, 32'hFFFF_FFFC}, 1'b0, NIL_RET},
		'{'{OP_FIRST_UNUSED, 5'd7, 5'd1, 5'd2, 32'd0}, 1'b0, NIL_RET},
		'{'{OP_LAST_UNUSED, 5'd8, 5'd3, 5'd4, 32'd0}, 1'b0, NIL_RET},
		'{'{rieu_pkg::OP_MOVC, 5'd0, 5'd0, 5'd0, 32'd5}, 1'b0, NIL_RET},
		'{'{rieu_pkg::OP_BNZ, 5'd0, 5'd0, 5'd0, 32'd12}, 1'b0, NIL_RET},
		'{'{rieu_pkg::OP_MUL, 5'd13, 5'd2, 5'd2, 32'd0}, 1'b0, NIL_RET},
		'{'{rieu_pkg::OP_JUMP, 5'd0, 5'd31, 5'd0, 32'd1}, 1'b0, NIL_RET}
	};

	risc_instruction_execute_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.dest_reg      (dest_reg),
		.src_a_reg     (src_a_reg),
		.src_b_reg     (src_b_reg),
		.literal       (literal),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.next_pc       (next_pc),
		.reg_written   (reg_written),
		.written_index (written_index),
		.written_value (written_value),
		.zero_now      (zero_now),
		.halted_now    (halted_now),
		.address_fault (address_fault)
	);

	always #4 clk = ~clk;

	function automatic logic [31:0] code_end(input logic [12:0] cw);
		return rieu_pkg::PC_BASE + 32'(cw) * rieu_pkg::WORD_BYTES - rieu_pkg::WORD_BYTES;
	endfunction

	function automatic retire_t retire_instr(input instr_t it);
		retire_t     r;
		logic [31:0] a, b, sum, nxt, res;
		logic        alu, wr, flt;
		r = '0;
		if (stopped) begin
			r.next_pc = arch_pc;
			r.zero    = zflag;
			r.halt    = 1'b1;
			return r;
		end
		a   = arch_regs[it.ra];
		b   = arch_regs[it.rb];
		nxt = arch_pc + rieu_pkg::WORD_BYTES;
		res = '0;
		alu = 1'b0;
		wr  = 1'b0;
		flt = 1'b0;
		case (it.op)
			rieu_pkg::OP_MOVC: begin res = it.lit; alu = 1'b1; end
			rieu_pkg::OP_ADD:  begin res = a + b; alu = 1'b1; end
			rieu_pkg::OP_SUB:  begin res = a - b; alu = 1'b1; end
			rieu_pkg::OP_MUL:  begin res = a * b; alu = 1'b1; end
			rieu_pkg::OP_AND:  begin res = a & b; alu = 1'b1; end
			rieu_pkg::OP_OR:   begin res = a | b; alu = 1'b1; end
			rieu_pkg::OP_EXOR: begin res = a ^ b; alu = 1'b1; end
			rieu_pkg::OP_LOAD: begin
				sum = a + it.lit;
				if ((sum >> 2) < 32'(MEM_WORDS)) begin
					res = data_mem[sum[13:2]];
					wr  = 1'b1;
				end else begin
					flt = 1'b1;
				end
			end
			rieu_pkg::OP_STORE: begin
				sum = b + it.lit;
				if ((sum >> 2) < 32'(MEM_WORDS))
					data_mem[sum[13:2]] = a;
				else
					flt = 1'b1;
			end
			rieu_pkg::OP_BZ:   if (zflag) nxt = arch_pc + it.lit;
			rieu_pkg::OP_BNZ:  if (!zflag) nxt = arch_pc + it.lit;
			rieu_pkg::OP_JUMP: nxt = a + it.lit;
			rieu_pkg::OP_HALT: stopped = 1'b1;
			default: ;
		endcase
		if (alu) begin
			zflag = (res == '0);
			wr    = 1'b1;
		end
		if (wr)
			arch_regs[it.rd] = res;
		if (arch_pc == code_end(cw_now))
			stopped = 1'b1;
		arch_pc   = nxt;
		r.next_pc = nxt;
		r.wr      = wr;
		r.idx     = wr ? it.rd : 5'd0;
		r.value   = wr ? res : 32'd0;
		r.zero    = zflag;
		r.halt    = stopped;
		r.fault   = flt;
		return r;
	endfunction

	// Random instruction that keeps the program off the last code word.
	function automatic instr_t pick_instr();
		instr_t      it;
		int          sel, word;
		logic [31:0] base, dest_pc;
		do begin
			it.rd  = 5'($urandom_range(0, 31));
			it.ra  = 5'($urandom_range(0, 31));
			it.rb  = 5'($urandom_range(0, 31));
			it.lit = $urandom;
			sel    = $urandom_range(0, 99);
			if (sel < 12) begin
				it.op = rieu_pkg::OP_MOVC;
				case ($urandom_range(0, 3))
					0: it.lit = '0;
					1: it.lit = 32'($urandom_range(0, 15));
					2: it.lit = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
					default: ;
				endcase
			end else if (sel < 50) begin
				it.op = 4'($urandom_range(rieu_pkg::OP_ADD, rieu_pkg::OP_EXOR));
				if ($urandom_range(0, 7) == 0)
					it.rb = it.ra;
			end else if (sel < 76) begin
				it.op = $urandom_range(0, 1) ? rieu_pkg::OP_LOAD : rieu_pkg::OP_STORE;
				base  = arch_regs[(it.op == rieu_pkg::OP_LOAD) ? it.ra : it.rb];
				word  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MEM_WORDS - 1)
					: $urandom_range(0, 31);
				case ($urandom_range(0, 9))
					8: it.lit = 32'(MEM_WORDS) * 4 + 32'($urandom_range(0, 3)) - base;
					9: ;
					default: it.lit = 32'(word) * 4 + 32'($urandom_range(0, 3)) - base;
				endcase
			end else if (sel < 88) begin
				it.op = $urandom_range(0, 1) ? rieu_pkg::OP_BZ : rieu_pkg::OP_BNZ;
				if ($urandom_range(0, 7) != 0)
					it.lit = 32'(($urandom_range(0, 64) - 32) * 4);
			end else if (sel < 95) begin
				it.op = rieu_pkg::OP_JUMP;
				if ($urandom_range(0, 3) != 0)
					it.lit = rieu_pkg::PC_BASE + 32'($urandom_range(0, 8191)) * 4
						- arch_regs[it.ra];
			end else begin
				it.op = 4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
			end
			case (it.op)
				rieu_pkg::OP_BZ:
					dest_pc = zflag ? arch_pc + it.lit : arch_pc + rieu_pkg::WORD_BYTES;
				rieu_pkg::OP_BNZ:
					dest_pc = zflag ? arch_pc + rieu_pkg::WORD_BYTES : arch_pc + it.lit;
				rieu_pkg::OP_JUMP:
					dest_pc = arch_regs[it.ra] + it.lit;
				default:
					dest_pc = arch_pc + rieu_pkg::WORD_BYTES;
			endcase
		end while (!stopped && dest_pc == code_end(cw_now));
		return it;
	endfunction

	task automatic issue(input instr_t it, input bit typed = 1'b0, input retire_t want = '0);
		retire_t pred;
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		req_type  <= it.op;
		dest_reg  <= it.rd;
		src_a_reg <= it.ra;
		src_b_reg <= it.rb;
		literal   <= it.lit;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pred = retire_instr(it);
		pending_retire.push_back(typed ? want : pred);
	endtask

	task automatic set_code_words(input logic [12:0] cw);
		logic [12:0] v;
		v = cw;
		if (code_end(v) == arch_pc)
			v = v ^ 13'd1;
		in_valid <= 1'b0;
		while (pending_retire.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cw_now = v;
	endtask

	initial begin
		instr_t it;
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		in_valid    <= 1'b0;
		req_type    <= '0;
		dest_reg    <= '0;
		src_a_reg   <= '0;
		src_b_reg   <= '0;
		literal     <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			issue(plan[i].ins, plan[i].typed, plan[i].want);

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				1: set_code_words(13'd1);
				2: set_code_words(13'd8191);
				3: set_code_words(13'd0);
				4: set_code_words(13'($urandom_range(2, 8190)));
				5: set_code_words(rieu_pkg::CODE_WORDS_RST);
				default: ;
			endcase
			repeat (PHASE_ITEMS) issue(pick_instr());
		end

		set_code_words(13'($urandom_range(1, 4096)));
		calm = 1'b1;
		repeat (100) issue(pick_instr());
		// stop either by HALT or by retiring the last code word
		it = pick_instr();
		if ($urandom_range(0, 1)) begin
			it.op = rieu_pkg::OP_HALT;
			issue(it);
		end else begin
			it.op  = rieu_pkg::OP_JUMP;
			it.lit = code_end(cw_now) - arch_regs[it.ra];
			issue(it);
			issue(pick_instr());
		end
		repeat (8) issue(pick_instr());

		in_valid <= 1'b0;
		while (pending_retire.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		mism_cnt += pending_retire.size();
		if (mism_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		out_ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : chk_retire
		retire_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = {next_pc, reg_written, written_index, written_value,
				zero_now, halted_now, address_fault};
			if (pending_retire.size() == 0) begin
				if (mism_cnt < 10)
					$display("unexpected retire: %p", got);
				mism_cnt++;
			end else begin
				want = pending_retire.pop_front();
				if (got !== want) begin
					if (mism_cnt < 10)
						$display("retire mismatch: expected %p, got %p", want, got);
					mism_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_count = 0;
		else
			stall_count++;
		if (stall_count >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

endmodule
